// File: hdl/pscm_pkg.sv
`timescale 1ns / 1ps
// Shared types and character codes for the Python string and comment masker.
// Depends on nothing; used by pscm_lexer and python_string_comment_masker.
package pscm_pkg;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [2:0] {
		MODE_CODE    = 3'd0,
		MODE_SQ      = 3'd1,
		MODE_DQ      = 3'd2,
		MODE_TSQ     = 3'd3,
		MODE_TDQ     = 3'd4,
		MODE_COMMENT = 3'd5
	} lex_mode_t;

	// Scanner state carried from one byte to the next.
	typedef struct packed {
		lex_mode_t   mode;
		logic        escape_pending;
		logic        string_fresh;
		logic        empty_pair_pending;
		logic        empty_pair_kind;    // 0 single quote, 1 double quote
		logic [1:0]  close_quote_run;
	} lex_state_t;

	localparam lex_state_t LEX_STATE_RESET = '{
		mode:               MODE_CODE,
		escape_pending:     1'b0,
		string_fresh:       1'b0,
		empty_pair_pending: 1'b0,
		empty_pair_kind:    1'b0,
		close_quote_run:    2'd0
	};

endpackage

// File: hdl/pscm_lexer.sv
`timescale 1ns / 1ps
// Combinational next-state and masking logic for one source byte.
// Depends on pscm_pkg for the mode enum, state struct and character codes.
module pscm_lexer (
	input  pscm_pkg::lex_state_t cur,
	input  logic [7:0]           text_byte,
	input  logic                 end_of_text,
	output pscm_pkg::lex_state_t nxt,
	output logic [7:0]           masked_byte
);

	logic [7:0] blank;
	logic [7:0] str_quote;
	logic [7:0] tri_quote;
	logic [7:0] pair_quote;
	pscm_pkg::lex_state_t upd;

	assign blank      = (text_byte == pscm_pkg::CH_NL) ? pscm_pkg::CH_NL : pscm_pkg::CH_SPACE;
	assign str_quote  = (cur.mode == pscm_pkg::MODE_SQ) ? pscm_pkg::CH_SQUOTE
		: pscm_pkg::CH_DQUOTE;
	assign tri_quote  = (cur.mode == pscm_pkg::MODE_TSQ) ? pscm_pkg::CH_SQUOTE
		: pscm_pkg::CH_DQUOTE;
	assign pair_quote = cur.empty_pair_kind ? pscm_pkg::CH_DQUOTE : pscm_pkg::CH_SQUOTE;

	always_comb begin
		upd         = cur;
		masked_byte = text_byte;
		unique case (cur.mode)
			pscm_pkg::MODE_COMMENT: begin
				if (text_byte == pscm_pkg::CH_NL) begin
					upd.mode    = pscm_pkg::MODE_CODE;
					masked_byte = pscm_pkg::CH_NL;
				end else begin
					masked_byte = pscm_pkg::CH_SPACE;
				end
			end
			pscm_pkg::MODE_SQ, pscm_pkg::MODE_DQ: begin
				upd.string_fresh = 1'b0;
				masked_byte      = blank;
				if (cur.escape_pending) begin
					upd.escape_pending = 1'b0;
				end else if (text_byte == pscm_pkg::CH_BSLASH) begin
					upd.escape_pending = 1'b1;
				end else if (text_byte == str_quote) begin
					// closing quote right after the opener: remember the empty pair
					if (cur.string_fresh) begin
						upd.empty_pair_pending = 1'b1;
						upd.empty_pair_kind    = (cur.mode == pscm_pkg::MODE_DQ);
					end
					upd.mode = pscm_pkg::MODE_CODE;
				end
			end
			pscm_pkg::MODE_TSQ, pscm_pkg::MODE_TDQ: begin
				masked_byte = blank;
				if (text_byte == tri_quote) begin
					if (cur.close_quote_run >= 2'd2) begin
						upd.close_quote_run = 2'd0;
						upd.mode            = pscm_pkg::MODE_CODE;
					end else begin
						upd.close_quote_run = cur.close_quote_run + 2'd1;
					end
				end else begin
					upd.close_quote_run = 2'd0;
				end
			end
			default: begin
				// code mode; unused codes behave the same way
				upd.empty_pair_pending = 1'b0;
				priority if (cur.empty_pair_pending && text_byte == pair_quote) begin
					upd.mode            = cur.empty_pair_kind ? pscm_pkg::MODE_TDQ
						: pscm_pkg::MODE_TSQ;
					upd.close_quote_run = 2'd0;
					masked_byte         = pscm_pkg::CH_SPACE;
				end else if (text_byte == pscm_pkg::CH_HASH) begin
					upd.mode    = pscm_pkg::MODE_COMMENT;
					masked_byte = pscm_pkg::CH_SPACE;
				end else if (text_byte == pscm_pkg::CH_SQUOTE
						|| text_byte == pscm_pkg::CH_DQUOTE) begin
					upd.mode           = (text_byte == pscm_pkg::CH_SQUOTE)
						? pscm_pkg::MODE_SQ : pscm_pkg::MODE_DQ;
					upd.string_fresh   = 1'b1;
					upd.escape_pending = 1'b0;
					masked_byte        = pscm_pkg::CH_SPACE;
				end else begin
					masked_byte = text_byte;
				end
			end
		endcase
		nxt = end_of_text ? pscm_pkg::LEX_STATE_RESET : upd;
	end

endmodule

// File: hdl/python_string_comment_masker.sv
`timescale 1ns / 1ps
// Top level of the Python string and comment masker: handshake, state and result register.
// Depends on pscm_pkg and pscm_lexer.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   input   | in        | in_valid / in_ready  | text_byte, end_of_text
//   output  | out       | out_valid / out_ready| masked_byte, end_of_text_out
//
// One request per cycle while results are taken: each accepted byte is masked
// in the same cycle and its result lands in the output register on that edge;
// throughput is one byte per clock. The scanner state register
// advances on every accepted request. in_ready is high while the output
// register is empty or being drained, so a stall downstream holds input only
// when a result is waiting and not taken. Reset (arst_n low) empties the
// output register and returns the scanner to code mode.
module python_string_comment_masker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] masked_byte,
	output logic       end_of_text_out
);

	pscm_pkg::lex_state_t state_q;
	pscm_pkg::lex_state_t state_nxt;
	logic [7:0]           mask_nxt;
	logic                 out_valid_q;
	logic [7:0]           masked_q;
	logic                 eot_q;
	logic                 in_fire;

	// Accept while the result slot is free or its request leaves this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	pscm_lexer u_lexer (
		.cur         (state_q),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.nxt         (state_nxt),
		.masked_byte (mask_nxt)
	);

	// Scanner state: advance only on an accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pscm_pkg::LEX_STATE_RESET;
		end else if (in_fire) begin
			state_q <= state_nxt;
		end
	end

	// Result valid flag: set on accept, drop when taken with nothing new.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: no reset needed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			masked_q <= mask_nxt;
			eot_q    <= end_of_text;
		end
	end

	assign out_valid       = out_valid_q;
	assign masked_byte     = masked_q;
	assign end_of_text_out = eot_q;

	// End of text leaves the scanner in plain code mode.
	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && end_of_text |=> state_q == pscm_pkg::LEX_STATE_RESET)
		else $error("scanner state not cleared after end of text");

	// A newline byte always comes out as a newline.
	a_newline_kept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && text_byte == pscm_pkg::CH_NL |=> masked_byte == pscm_pkg::CH_NL)
		else $error("newline was masked");

	// A pending escape only exists inside a single-line quoted string.
	a_escape_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.escape_pending |->
			(state_q.mode == pscm_pkg::MODE_SQ || state_q.mode == pscm_pkg::MODE_DQ))
		else $error("escape pending outside quoted string");

	// Closing-quote counting only happens inside a triple-quoted string.
	a_run_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.close_quote_run != 2'd0 |->
			(state_q.mode == pscm_pkg::MODE_TSQ || state_q.mode == pscm_pkg::MODE_TDQ))
		else $error("close quote run outside triple string");

endmodule
